@@ rtl/distance_constraint_projection_assert.svh @@
// assertion macros shared by the distance constraint projection rtl
// expects clk and rst in the scope of each use
`ifndef DISTANCE_CONSTRAINT_PROJECTION_ASSERT_SVH
`define DISTANCE_CONSTRAINT_PROJECTION_ASSERT_SVH

// same-cycle implication
`define DCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dcp assertion failed");

// next-cycle implication
`define DCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dcp assertion failed");

`endif

@@ rtl/dcp_pkg.sv @@
// widths, word types and constants of the distance constraint projection
// no dependencies
`timescale 1ns / 1ps

package dcp_pkg;

  localparam int MAG_W   = 32;
  localparam int SQ_W    = 66;
  localparam int ROOT_W  = 33;
  localparam int TRIAL_W = SQ_W + 2;
  localparam int KW_W    = 40;
  localparam int WSUM_W  = 25;
  localparam int REST_W  = 31;
  localparam int NUM_W   = 105;
  localparam int DEN_W   = 74;
  localparam int QUO_W   = 33;
  localparam int DIV_W   = DEN_W + QUO_W;
  localparam int LANES   = 6;
  localparam int AXES    = 3;
  localparam int STIFF_W = 17;
  localparam logic [STIFF_W-1:0] STIFF_ONE = 17'h10000;

  // per-item data carried along the root chain
  typedef struct packed {
    logic [AXES-1:0][MAG_W-1:0] mag;
    logic [AXES-1:0]            dneg;
    logic [KW_W-1:0]            kw0;
    logic [KW_W-1:0]            kw1;
    logic [WSUM_W-1:0]          wsum;
    logic [REST_W-1:0]          rest;
    logic                       applied;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } root_word_t;

  typedef struct packed {
    logic                        valid;
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [DEN_W-1:0]            den;
    logic [AXES-1:0]             neg;
    logic                        zero;
    logic                        applied;
  } div_word_t;

endpackage

@@ rtl/dcp_sqrt_cell.sv @@
// one cell of the integer square root chain, settles one root bit
// depends on dcp_pkg
`timescale 1ns / 1ps

module dcp_sqrt_cell import dcp_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  root_word_t in_word,
  output root_word_t out_word
);

  logic [TRIAL_W-1:0] trial;
  root_word_t         word_next;

  // remainder form: rem = s - root^2, trial = 2*root*2^b + 2^(2b)
  always_comb begin
    trial = (TRIAL_W'(in_word.root) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
    word_next = in_word;
    if (trial <= TRIAL_W'(in_word.rem)) begin
      word_next.rem = in_word.rem - trial[SQ_W-1:0];
      word_next.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (en) begin
      out_word <= word_next;
    end
  end

endmodule

@@ rtl/dcp_div_cell.sv @@
// one cell of the restoring divider chain, one quotient bit for all six lanes
// depends on dcp_pkg
`timescale 1ns / 1ps

module dcp_div_cell import dcp_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  div_word_t in_word,
  output div_word_t out_word
);

  logic [DIV_W-1:0] shifted;
  div_word_t        word_next;

  always_comb begin
    shifted = DIV_W'(in_word.den) << BIT;
    word_next = in_word;
    for (int l = 0; l < LANES; l++) begin
      if (DIV_W'(in_word.rem[l]) >= shifted) begin
        word_next.rem[l] = in_word.rem[l] - shifted[NUM_W-1:0];
        word_next.quo[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (en) begin
      out_word <= word_next;
    end
  end

endmodule

@@ rtl/distance_constraint_projection.sv @@
// distance constraint projection: top level with front math, root and divider
// chains, correction packing and output buffer; depends on dcp_pkg, dcp_sqrt_cell,
// dcp_div_cell and distance_constraint_projection_assert.svh
//
// usage
//   input channel in_valid/in_ready carries one word per constraint: both
//   positions, both inverse masses and the rest length
//   output channel out_valid/out_ready carries one word per input word: the six
//   saturated corrections and the applied flag, in input order
//   stiffness_gain is written through cfg_write_en/cfg_write_data while idle;
//   values above 1.0 act as 1.0
//   throughput: one word per cycle while the skid entry is empty, set by the
//   fully pipelined chains: 33 root cells (one root bit each) and 33 divider
//   cells (one quotient bit each)
//   reset: clears every stage valid bit and the output buffer, stiffness = 1.0
//   stall: a two-entry output buffer (output register plus skid) lets the chain
//   keep moving after out_ready drops until the skid entry fills; in_ready falls
//   only once the skid entry is full, and the whole chain holds until it drains
`timescale 1ns / 1ps
`include "distance_constraint_projection_assert.svh"

module distance_constraint_projection import dcp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [STIFF_W-1:0]  cfg_write_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  first_x,
  input  logic signed [31:0]  first_y,
  input  logic signed [31:0]  first_z,
  input  logic [23:0]         first_inv_mass,
  input  logic signed [31:0]  second_x,
  input  logic signed [31:0]  second_y,
  input  logic signed [31:0]  second_z,
  input  logic [23:0]         second_inv_mass,
  input  logic [REST_W-1:0]   rest_length,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  first_dx,
  output logic signed [31:0]  first_dy,
  output logic signed [31:0]  first_dz,
  output logic signed [31:0]  second_dx,
  output logic signed [31:0]  second_dy,
  output logic signed [31:0]  second_dz,
  output logic                applied
);

  localparam int PROD_W  = MAG_W + ROOT_W;   // emag * mag
  localparam int CHUNK_W = 22;               // split of the wide product
  localparam int PART_W  = KW_W + CHUNK_W;
  localparam int WD_W    = WSUM_W + ROOT_W;

  typedef struct packed {
    logic  valid;
    side_t side;
  } front_t;

  typedef struct packed {
    logic                          valid;
    logic [AXES-1:0][2*MAG_W-1:0]  sq;
    side_t                         side;
  } square_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] emag;
    logic              eneg;
    logic [DEN_W-1:0]  den;
    logic              zero;
    side_t             side;
  } err_t;

  typedef struct packed {
    logic                         valid;
    logic [AXES-1:0][PROD_W-1:0]  prod;
    logic [KW_W-1:0]              kw0;
    logic [KW_W-1:0]              kw1;
    logic [DEN_W-1:0]             den;
    logic [AXES-1:0]              neg;
    logic                         zero;
    logic                         applied;
  } prod_t;

  typedef struct packed {
    logic                               valid;
    logic [LANES-1:0][2:0][PART_W-1:0]  part;
    logic [DEN_W-1:0]                   den;
    logic [AXES-1:0]                    neg;
    logic                               zero;
    logic                               applied;
  } part_t;

  typedef struct packed {
    logic [LANES-1:0][31:0] corr;
    logic                   applied;
  } result_t;

  // stiffness register
  logic [STIFF_W-1:0] stiffness_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness_gain <= STIFF_ONE;
    end else if (cfg_write_en) begin
      stiffness_gain <= cfg_write_data;
    end
  end

  // chain advance: everything moves unless the skid entry is occupied
  logic    en;
  logic    skid_valid;
  result_t skid_data;
  result_t out_data;
  logic    t_valid;
  result_t t_data;

  assign en       = !skid_valid;
  assign in_ready = en;

  // front: differences, magnitudes, stiffness times inverse masses
  side_t                     in_side;
  logic [AXES-1:0][31:0]     pos_a;
  logic [AXES-1:0][31:0]     pos_b;
  logic signed [32:0]        diff;
  logic [STIFF_W-1:0]        k_eff;
  logic [KW_W:0]             kw0_full;
  logic [KW_W:0]             kw1_full;

  assign pos_a = {first_z, first_y, first_x};
  assign pos_b = {second_z, second_y, second_x};

  always_comb begin
    diff = '0;
    for (int c = 0; c < AXES; c++) begin
      diff = $signed({pos_b[c][31], pos_b[c]}) - $signed({pos_a[c][31], pos_a[c]});
      in_side.dneg[c] = diff[32];
      in_side.mag[c]  = diff[32] ? 32'(-diff) : diff[31:0];
    end
    k_eff    = (stiffness_gain > STIFF_ONE) ? STIFF_ONE : stiffness_gain;
    kw0_full = k_eff * first_inv_mass;
    kw1_full = k_eff * second_inv_mass;
    in_side.kw0     = kw0_full[KW_W-1:0];
    in_side.kw1     = kw1_full[KW_W-1:0];
    in_side.wsum    = WSUM_W'(first_inv_mass) + WSUM_W'(second_inv_mass);
    in_side.rest    = rest_length;
    in_side.applied = (first_inv_mass != '0) || (second_inv_mass != '0);
  end

  front_t front;

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (en) begin
      front.valid <= in_valid;
      front.side  <= in_side;
    end
  end

  // squares of the components
  square_t square;

  always_ff @(posedge clk) begin
    if (rst) begin
      square.valid <= 1'b0;
    end else if (en) begin
      square.valid <= front.valid;
      square.side  <= front.side;
      for (int c = 0; c < AXES; c++) begin
        square.sq[c] <= front.side.mag[c] * front.side.mag[c];
      end
    end
  end

  // squared length enters the root chain
  root_word_t root_chain [ROOT_W+1];
  root_word_t root_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_head.valid <= 1'b0;
    end else if (en) begin
      root_head.valid <= square.valid;
      root_head.rem   <= SQ_W'(square.sq[0]) + SQ_W'(square.sq[1]) + SQ_W'(square.sq[2]);
      root_head.root  <= '0;
      root_head.side  <= square.side;
    end
  end

  assign root_chain[0] = root_head;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    dcp_sqrt_cell #(.BIT(ROOT_W - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_word  (root_chain[i]),
      .out_word (root_chain[i+1])
    );
  end

  // length error and denominator (wsum * d, scaled by 2^16)
  root_word_t        root_tail;
  logic [WD_W-1:0]   wd;
  logic              eneg_c;
  err_t              err;

  assign root_tail = root_chain[ROOT_W];
  assign eneg_c    = root_tail.root < ROOT_W'(root_tail.side.rest);
  assign wd        = root_tail.side.wsum * root_tail.root;

  always_ff @(posedge clk) begin
    if (rst) begin
      err.valid <= 1'b0;
    end else if (en) begin
      err.valid <= root_tail.valid;
      err.eneg  <= eneg_c;
      err.emag  <= eneg_c ? ROOT_W'(root_tail.side.rest) - root_tail.root
                          : root_tail.root - ROOT_W'(root_tail.side.rest);
      err.den   <= {wd, 16'b0};
      // fixed pair or zero length gives zero corrections
      err.zero  <= !root_tail.side.applied || (root_tail.root == '0);
      err.side  <= root_tail.side;
    end
  end

  // error times each component magnitude
  prod_t prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (en) begin
      prod.valid   <= err.valid;
      prod.kw0     <= err.side.kw0;
      prod.kw1     <= err.side.kw1;
      prod.den     <= err.den;
      prod.zero    <= err.zero;
      prod.applied <= err.side.applied;
      for (int c = 0; c < AXES; c++) begin
        prod.prod[c] <= err.emag * err.side.mag[c];
        prod.neg[c]  <= err.eneg ^ err.side.dneg[c];
      end
    end
  end

  // stiffness-weight times product, in three partial products per lane
  part_t part;

  always_ff @(posedge clk) begin
    if (rst) begin
      part.valid <= 1'b0;
    end else if (en) begin
      part.valid   <= prod.valid;
      part.den     <= prod.den;
      part.neg     <= prod.neg;
      part.zero    <= prod.zero;
      part.applied <= prod.applied;
      for (int l = 0; l < LANES; l++) begin
        part.part[l][0] <= (l < AXES ? prod.kw0 : prod.kw1)
                           * prod.prod[l % AXES][CHUNK_W-1:0];
        part.part[l][1] <= (l < AXES ? prod.kw0 : prod.kw1)
                           * prod.prod[l % AXES][2*CHUNK_W-1:CHUNK_W];
        part.part[l][2] <= (l < AXES ? prod.kw0 : prod.kw1)
                           * PART_W'(prod.prod[l % AXES][PROD_W-1:2*CHUNK_W]);
      end
    end
  end

  // numerators assembled, divider chain
  div_word_t div_chain [QUO_W+1];
  div_word_t div_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_head.valid <= 1'b0;
    end else if (en) begin
      div_head.valid   <= part.valid;
      div_head.den     <= part.den;
      div_head.neg     <= part.neg;
      div_head.zero    <= part.zero;
      div_head.applied <= part.applied;
      div_head.quo     <= '0;
      for (int l = 0; l < LANES; l++) begin
        div_head.rem[l] <= NUM_W'(part.part[l][0])
                         + (NUM_W'(part.part[l][1]) << CHUNK_W)
                         + (NUM_W'(part.part[l][2]) << (2 * CHUNK_W));
      end
    end
  end

  assign div_chain[0] = div_head;

  // quotient never exceeds the length error, so QUO_W bits cover it
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    dcp_div_cell #(.BIT(QUO_W - 1 - i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_word  (div_chain[i]),
      .out_word (div_chain[i+1])
    );
  end

  // sign and saturation
  div_word_t div_tail;
  result_t   packed_res;
  logic      lane_neg;

  assign div_tail = div_chain[QUO_W];

  always_comb begin
    lane_neg = 1'b0;
    packed_res.applied = div_tail.applied;
    for (int l = 0; l < LANES; l++) begin
      // second particle moves against the first
      lane_neg = (l < AXES) ? div_tail.neg[l % AXES] : !div_tail.neg[l % AXES];
      if (div_tail.zero) begin
        packed_res.corr[l] = '0;
      end else if (lane_neg) begin
        packed_res.corr[l] = (div_tail.quo[l] >= QUO_W'(33'h0_8000_0000))
                           ? 32'h8000_0000 : 32'(0) - div_tail.quo[l][31:0];
      end else begin
        packed_res.corr[l] = (div_tail.quo[l] > QUO_W'(33'h0_7FFF_FFFF))
                           ? 32'h7FFF_FFFF : div_tail.quo[l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (en) begin
      t_valid <= div_tail.valid;
      t_data  <= packed_res;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_ready) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (t_valid) begin
        if (out_valid && !out_ready) begin
          skid_valid <= 1'b1;
          skid_data  <= t_data;
        end else begin
          out_valid <= 1'b1;
          out_data  <= t_data;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign first_dx  = out_data.corr[0];
  assign first_dy  = out_data.corr[1];
  assign first_dz  = out_data.corr[2];
  assign second_dx = out_data.corr[3];
  assign second_dy = out_data.corr[4];
  assign second_dz = out_data.corr[5];
  assign applied   = out_data.applied;

  // helpers for the checks below
  logic skid_fill;
  logic out_all_zero;

  assign skid_fill    = t_valid && out_valid && !out_ready;
  assign out_all_zero = (out_data.corr == '0);

  // skid entry only ever backs a full output register
  `DCP_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid)
  // skid fills only from a stalled output with a word arriving
  `DCP_ASSERT_NEXT(a_skid_fill_cause, !skid_valid && !skid_fill, !skid_valid)
  // a fully fixed pair is never moved
  `DCP_ASSERT_IMP(a_fixed_pair_zero, out_valid && !applied, out_all_zero)
  // corrections along x push the particles opposite ways
  `DCP_ASSERT_IMP(a_opposite_x, out_valid && first_dx != 0 && second_dx != 0, first_dx[31] != second_dx[31])

endmodule

@@ bench/distance_constraint_projection_test.sv @@
// testbench for the distance constraint projection: directed and random constraints
// checked against an exact integer predictor; depends on dcp_pkg and the rtl top level
`timescale 1ns / 1ps

module distance_constraint_projection_test import dcp_pkg::*; ();

  localparam int LATENCY     = 74;
  localparam int WATCH_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_ITEMS = 1000;

  // one input word as the sender sees it
  typedef struct {
    logic signed [31:0] ax, ay, az;
    logic [23:0]        aw;
    logic signed [31:0] bx, by, bz;
    logic [23:0]        bw;
    logic [30:0]        rest;
  } constraint_t;

  // one result word: first dx,dy,dz then second dx,dy,dz
  typedef struct {
    logic [5:0][31:0] corr;
    logic             applied;
  } correction_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [STIFF_W-1:0] cfg_write_data;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] first_x, first_y, first_z;
  logic [23:0] first_inv_mass;
  logic signed [31:0] second_x, second_y, second_z;
  logic [23:0] second_inv_mass;
  logic [REST_W-1:0] rest_length;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] first_dx, first_dy, first_dz;
  logic signed [31:0] second_dx, second_dy, second_dz;
  logic applied;

  // predictor state: the stiffness as last written
  logic [STIFF_W-1:0] stiffness;
  correction_t pending_corrections[$];

  int errors;
  int words_sent;
  int words_checked;
  int gain_settings;
  int idle_cycles;
  int hold_requests;
  bit random_ready;

  distance_constraint_projection dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .first_x(first_x),
    .first_y(first_y),
    .first_z(first_z),
    .first_inv_mass(first_inv_mass),
    .second_x(second_x),
    .second_y(second_y),
    .second_z(second_z),
    .second_inv_mass(second_inv_mass),
    .rest_length(rest_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .first_dx(first_dx),
    .first_dy(first_dy),
    .first_dz(first_dz),
    .second_dx(second_dx),
    .second_dy(second_dy),
    .second_dz(second_dz),
    .applied(applied)
  );

  // free-running clock, 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // signed magnitude to a saturated 32-bit pattern
  function automatic logic [31:0] saturate(bit neg, logic [127:0] mag);
    if (neg) begin
      if (mag >= 128'h8000_0000) return 32'h8000_0000;
      return 32'h0 - mag[31:0];
    end
    if (mag > 128'h7fff_ffff) return 32'h7fff_ffff;
    return mag[31:0];
  endfunction

  // exact projection: k*w_i*(d-rest)*diff/(65536*(w0+w1)*d), truncated then saturated
  function automatic correction_t project(constraint_t c, logic [STIFF_W-1:0] gain);
    correction_t r;
    logic signed [33:0] diff;
    logic [127:0] mag[3];
    bit dneg[3];
    logic [127:0] sq, root, cand, k, wsum, emag, den, base0, base1, rest;
    bit eneg, neg;
    logic signed [31:0] a[3], b[3];
    r.corr = '0;
    r.applied = 1'b0;
    a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
    b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
    k = (gain > STIFF_ONE) ? 128'(STIFF_ONE) : 128'(gain);
    wsum = 128'(c.aw) + 128'(c.bw);
    if (wsum == 0) return r;
    r.applied = 1'b1;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      diff = 34'(b[i]) - 34'(a[i]);
      dneg[i] = diff < 0;
      mag[i] = dneg[i] ? 128'(-diff) : 128'(diff);
      sq = sq + mag[i] * mag[i];
    end
    root = '0;
    for (int bit_n = 33; bit_n >= 0; bit_n--) begin
      cand = root | (128'd1 << bit_n);
      if (cand * cand <= sq) root = cand;
    end
    if (root == 0) return r;
    rest = 128'(c.rest);
    eneg = root < rest;
    emag = eneg ? rest - root : root - rest;
    den = (wsum << 16) * root;
    base0 = k * 128'(c.aw) * emag;
    base1 = k * 128'(c.bw) * emag;
    for (int i = 0; i < 3; i++) begin
      neg = eneg ^ dneg[i];
      r.corr[i] = saturate(neg, (base0 * mag[i]) / den);
      r.corr[3 + i] = saturate(!neg, (base1 * mag[i]) / den);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on word %0d: %s got %h expected %h", words_checked, what, got, want);
  endtask

  // result checker: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    correction_t want;
    logic [5:0][31:0] got;
    string names[6];
    names = '{"first_dx", "first_dy", "first_dz", "second_dx", "second_dy", "second_dz"};
    if (!rst && out_valid && out_ready) begin
      got = {second_dz, second_dy, second_dx, first_dz, first_dy, first_dx};
      if (pending_corrections.size() == 0) begin
        report_mismatch("unexpected word", 32'(applied), 32'h0);
      end else begin
        want = pending_corrections.pop_front();
        for (int i = 0; i < 6; i++)
          if (got[i] !== want.corr[i]) report_mismatch(names[i], got[i], want.corr[i]);
        if (applied !== want.applied) report_mismatch("applied", 32'(applied), 32'(want.applied));
      end
      words_checked++;
    end
  end

  // watchdog: cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("watchdog expired with %0d words outstanding", pending_corrections.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver: own stall pattern, switching mode every so often, plus long holds
  initial begin
    int mode;
    int left;
    int hold;
    int holds_taken;
    mode = 0;
    left = 0;
    hold = 0;
    holds_taken = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_taken) begin
        hold = LONG_HOLD;
        holds_taken = hold_requests;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!random_ready) begin
        out_ready <= 1'b1;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // send one word: called at a falling edge, returns at the falling edge after acceptance
  task automatic send_constraint(constraint_t c);
    in_valid <= 1'b1;
    first_x <= c.ax;
    first_y <= c.ay;
    first_z <= c.az;
    first_inv_mass <= c.aw;
    second_x <= c.bx;
    second_y <= c.by;
    second_z <= c.bz;
    second_inv_mass <= c.bw;
    rest_length <= c.rest;
    do @(posedge clk); while (!in_ready);
    pending_corrections.push_back(project(c, stiffness));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // let every expected word arrive, then the pipe go quiet
  task automatic wait_drained();
    pause_sender(1);
    while (pending_corrections.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_stiffness(logic [STIFF_W-1:0] value);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    stiffness = value;
    gain_settings++;
  endtask

  function automatic constraint_t make_constraint(
      logic signed [31:0] ax, ay, az, logic [23:0] aw,
      logic signed [31:0] bx, by, bz, logic [23:0] bw, logic [30:0] rest);
    constraint_t c;
    c.ax = ax; c.ay = ay; c.az = az; c.aw = aw;
    c.bx = bx; c.by = by; c.bz = bz; c.bw = bw; c.rest = rest;
    return c;
  endfunction

  // random constraint: mostly nearby particles with rest near their distance
  function automatic constraint_t random_constraint();
    constraint_t c;
    int mode;
    int span;
    mode = $urandom_range(0, 9);
    c.ax = $urandom; c.ay = $urandom; c.az = $urandom;
    c.bx = $urandom; c.by = $urandom; c.bz = $urandom;
    c.aw = 24'($urandom); c.bw = 24'($urandom);
    c.rest = 31'($urandom);
    if (mode < 7) begin
      span = 1 << $urandom_range(1, 24);
      c.bx = c.ax + $signed($urandom_range(0, 2 * span)) - span;
      c.by = c.ay + $signed($urandom_range(0, 2 * span)) - span;
      c.bz = c.az + $signed($urandom_range(0, 2 * span)) - span;
      c.rest = 31'($urandom_range(0, 2 * span));
      if ($urandom_range(0, 1) == 1) c.aw = 24'($urandom_range(0, 1 << 17));
      if ($urandom_range(0, 1) == 1) c.bw = 24'($urandom_range(0, 1 << 17));
    end else if (mode == 7) begin
      c.bx = c.ax; c.by = c.ay; c.bz = c.az;
    end
    if ($urandom_range(0, 9) == 0) c.aw = '0;
    if ($urandom_range(0, 9) == 0) c.bw = '0;
    return c;
  endfunction

  // extremes and each special case
  task automatic test_directed();
    constraint_t c[$];
    c.push_back(make_constraint(0, 0, 0, 24'h010000, 32'h10000, 0, 0, 24'h010000, 0));
    c.push_back(make_constraint(0, 0, 0, 0, 32'h30000, 32'h40000, 0, 0, 31'h10000));
    c.push_back(make_constraint(5, 6, 7, 24'h010000, 5, 6, 7, 24'h020000, 31'h10000));
    c.push_back(make_constraint(0, 0, 0, 0, 32'h30000, 32'h40000, 0, 24'h010000, 31'h10000));
    c.push_back(make_constraint(0, 0, 0, 24'h010000, 32'h30000, 32'h40000, 0, 0, 31'h10000));
    c.push_back(make_constraint(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 24'hffffff,
        32'h80000000, 32'h80000000, 32'h80000000, 24'hffffff, 0));
    c.push_back(make_constraint(32'h80000000, 32'h80000000, 32'h80000000, 24'hffffff,
        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 24'h000001, 31'h7fffffff));
    c.push_back(make_constraint(0, 0, 0, 24'h000001, 1, 0, 0, 24'hffffff, 31'h7fffffff));
    c.push_back(make_constraint(0, 0, 0, 24'hffffff, 0, 0, 1, 24'hffffff, 0));
    c.push_back(make_constraint(32'h10000, 32'h20000, 32'h30000, 24'h008000,
        32'hffff0000, 32'hfffe0000, 32'hfffd0000, 24'h018000, 31'h20000));
    c.push_back(make_constraint(0, 0, 0, 24'h010000, 0, 0, 0, 24'h010000, 31'h7fffffff));
    c.push_back(make_constraint(32'h7fffffff, 0, 0, 24'h010000, 32'h80000000, 0, 0,
        24'h010000, 31'h7fffffff));
    c.push_back(make_constraint(32'hffffffff, 32'hffffffff, 32'hffffffff, 24'h800000,
        32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 24'h7fffff, 31'h2aaaaaaa));
    foreach (c[i]) send_constraint(c[i]);
    wait_drained();
  endtask

  // bursts of up to 24 words with random gaps, count words in all
  task automatic test_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && count > 0) begin
        send_constraint(random_constraint());
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    hold_requests++;
    repeat (150) send_constraint(random_constraint());
    wait_drained();
  endtask

  // sender waits for every result between short bursts
  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(2, 8)) send_constraint(random_constraint());
      wait_drained();
    end
  endtask

  initial begin
    logic [STIFF_W-1:0] gains[6];
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    gain_settings = 0;
    hold_requests = 0;
    random_ready = 1'b0;
    stiffness = STIFF_ONE;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    in_valid = 1'b0;
    first_x = '0; first_y = '0; first_z = '0; first_inv_mass = '0;
    second_x = '0; second_y = '0; second_z = '0; second_inv_mass = '0;
    rest_length = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset stiffness first, then the extremes and clamped values
    test_directed();
    gains = '{17'd0, 17'd1, 17'h1ffff, 17'hffff, 17'h10001, 17'h8000};
    foreach (gains[i]) begin
      write_stiffness(gains[i]);
      test_directed();
    end

    random_ready = 1'b1;
    for (int i = 0; i < 5; i++) begin
      write_stiffness(i == 0 ? STIFF_ONE : 17'($urandom_range(0, 17'h1ffff)));
      test_random(RANDOM_ITEMS / 5);
    end
    test_backpressure();
    test_drain_pause();

    wait_drained();
    $display("sent %0d constraints over %0d stiffness settings, checked %0d results",
        words_sent, gain_settings, words_checked);
    $display("%0d mismatches", errors);
    if (errors == 0 && pending_corrections.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dcp_pkg.sv
rtl/dcp_sqrt_cell.sv
rtl/dcp_div_cell.sv
rtl/distance_constraint_projection.sv
bench/distance_constraint_projection_test.sv
